// ===== rtl/core/crm_pkg.sv =====
package crm_pkg;

    // fixed field widths
    localparam int COST_W  = 32;
    localparam int START_W = 40;
    localparam int BOUND_W = 44;
    localparam int IDX_IN_W = 4;
    localparam int CMD_W   = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 2'd0,
        CMD_REDUCE = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_UPD,
        ST_UPD_TAIL,
        ST_DONE
    } t_state;

    // one stored matrix entry
    typedef struct packed {
        logic              inf;
        logic [COST_W-1:0] val;
    } t_entry;

    // sequencer controls for the shared min/subtract/accumulate unit
    typedef struct packed {
        logic load_bound;
        logic clear_line;
        logic scan_en;
        logic acc_en;
    } t_alu_ctl;

endpackage

// ===== rtl/core/crm_if.sv =====
// input command word channel
interface crm_in_if;
    logic                            valid;
    logic                            ready;
    logic [crm_pkg::CMD_W-1:0]       command;
    logic [crm_pkg::IDX_IN_W-1:0]    row;
    logic [crm_pkg::IDX_IN_W-1:0]    col;
    logic [crm_pkg::COST_W-1:0]      cost;
    logic                            cost_is_inf;
    logic [crm_pkg::START_W-1:0]     start_cost;

    modport source (output valid, command, row, col, cost, cost_is_inf, start_cost,
                    input ready);
    modport sink   (input valid, command, row, col, cost, cost_is_inf, start_cost,
                    output ready);
endinterface

// result word channel
interface crm_out_if;
    logic                            valid;
    logic                            ready;
    logic [crm_pkg::COST_W-1:0]      entry_value;
    logic                            entry_is_inf;
    logic [crm_pkg::BOUND_W-1:0]     bound;

    modport source (output valid, entry_value, entry_is_inf, bound, input ready);
    modport sink   (input valid, entry_value, entry_is_inf, bound, output ready);
endinterface

// ===== rtl/core/cost_matrix_row_column_reduction_top.sv =====
// Reduced-cost matrix for branch-and-bound tour search. Holds a CITIES x CITIES
// matrix of 32-bit fixed-point costs (16 fraction bits) with an infinity flag,
// kept in one single-port-write, single-port-read memory with registered read
// data. A write gives no result; a read returns the entry through the registered
// memory read data and the output register, with out-of-range indexes
// reading as infinite. A reduce walks every row and then every column through
// the one memory port: a scan pass for the minimum and an update pass that
// writes back the reduced entries. It returns start cost plus all minima,
// saturated to 44 bits. Input is not taken while a command is in progress or an
// untaken result waits in the output register. The matrix has no defined
// contents after reset and is not cleared; entries must be written before they
// are read or reduced.
module cost_matrix_row_column_reduction_top #(
    parameter int CITIES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    crm_in_if.sink     i_in,
    crm_out_if.source  o_out
);
    import crm_pkg::*;

    localparam int IDX_W  = $clog2(CITIES);
    localparam int ADDR_W = 2 * IDX_W;
    localparam logic [IDX_W-1:0] LAST = IDX_W'(CITIES - 1);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_k, n_k;
    logic [IDX_W-1:0]   r_line, n_line;
    logic               r_col_phase, n_col_phase;
    logic               r_rd_scan, n_rd_scan;
    logic               r_rd_upd, n_rd_upd;
    logic [ADDR_W-1:0]  r_wr_addr, n_wr_addr;
    logic               r_rd_inrange, n_rd_inrange;
    logic               r_out_valid, n_out_valid;
    logic [COST_W-1:0]  r_out_value, n_out_value;
    logic               r_out_inf, n_out_inf;
    logic [BOUND_W-1:0] r_out_bound, n_out_bound;

    logic               w_accept;
    logic               w_in_range;
    logic [ADDR_W-1:0]  w_in_addr;
    logic [ADDR_W-1:0]  w_line_addr;
    logic               w_mem_we;
    logic [ADDR_W-1:0]  w_mem_waddr;
    t_entry             w_mem_wdata;
    logic [ADDR_W-1:0]  w_mem_raddr;
    t_entry             w_rdata;
    t_alu_ctl           w_ctl;
    logic               w_found;
    logic [COST_W-1:0]  w_diff;
    logic [BOUND_W-1:0] w_bound;

    // handshake: idle and output slot free or draining
    assign i_in.ready = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_in_range = ({4'b0, i_in.row} < 8'(CITIES)) && ({4'b0, i_in.col} < 8'(CITIES));
    assign w_in_addr  = {IDX_W'(i_in.row), IDX_W'(i_in.col)};

    // element k of the current row or column
    assign w_line_addr = r_col_phase ? {r_k, r_line} : {r_line, r_k};

    crm_mem #(.ADDR_W(ADDR_W)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_rdata)
    );

    crm_alu u_alu (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_start_cost (i_in.start_cost),
        .i_rdata      (w_rdata),
        .o_found      (w_found),
        .o_diff       (w_diff),
        .o_bound      (w_bound)
    );

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rd_scan   <= 1'b0;
            r_rd_upd    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_scan   <= n_rd_scan;
            r_rd_upd    <= n_rd_upd;
            r_out_valid <= n_out_valid;
        end
    end

    // sequencer counters and payload
    always_ff @(posedge i_clk) begin
        r_k          <= n_k;
        r_line       <= n_line;
        r_col_phase  <= n_col_phase;
        r_wr_addr    <= n_wr_addr;
        r_rd_inrange <= n_rd_inrange;
        r_out_value  <= n_out_value;
        r_out_inf    <= n_out_inf;
        r_out_bound  <= n_out_bound;
    end

    // next state, memory port and unit controls
    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_line       = r_line;
        n_col_phase  = r_col_phase;
        n_rd_scan    = 1'b0;
        n_rd_upd     = 1'b0;
        n_wr_addr    = r_wr_addr;
        n_rd_inrange = r_rd_inrange;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_value  = r_out_value;
        n_out_inf    = r_out_inf;
        n_out_bound  = r_out_bound;

        // update pass write-back: finite entries of a line that had a minimum
        w_mem_we    = r_rd_upd && w_found && !w_rdata.inf;
        w_mem_waddr = r_wr_addr;
        w_mem_wdata = '{inf: 1'b0, val: w_diff};
        w_mem_raddr = w_in_addr;

        w_ctl            = '0;
        w_ctl.scan_en    = r_rd_scan;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (t_cmd'(i_in.command))
                        CMD_WRITE: begin
                            w_mem_we    = w_in_range;
                            w_mem_waddr = w_in_addr;
                            w_mem_wdata = '{inf: i_in.cost_is_inf,
                                            val: i_in.cost_is_inf ? '0 : i_in.cost};
                        end
                        CMD_REDUCE: begin
                            w_ctl.load_bound = 1'b1;
                            n_k              = '0;
                            n_line           = '0;
                            n_col_phase      = 1'b0;
                            n_state          = ST_SCAN;
                        end
                        CMD_READ: begin
                            n_rd_inrange = w_in_range;
                            n_state      = ST_RD_WAIT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD_WAIT: begin
                n_out_valid = 1'b1;
                n_out_value = r_rd_inrange ? w_rdata.val : '0;
                n_out_inf   = r_rd_inrange ? w_rdata.inf : 1'b1;
                n_out_bound = '0;
                n_state     = ST_IDLE;
            end
            ST_SCAN: begin
                w_mem_raddr      = w_line_addr;
                n_rd_scan        = 1'b1;
                w_ctl.clear_line = (r_k == '0);
                if (r_k == LAST) begin
                    n_k     = '0;
                    n_state = ST_SCAN_TAIL;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_SCAN_TAIL: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                w_mem_raddr = w_line_addr;
                n_rd_upd    = 1'b1;
                n_wr_addr   = w_line_addr;
                if (r_k == LAST) begin
                    n_k     = '0;
                    n_state = ST_UPD_TAIL;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_UPD_TAIL: begin
                w_ctl.acc_en = 1'b1;
                if (r_line == LAST) begin
                    n_line = '0;
                    if (r_col_phase) begin
                        n_state = ST_DONE;
                    end else begin
                        n_col_phase = 1'b1;
                        n_state     = ST_SCAN;
                    end
                end else begin
                    n_line  = r_line + 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_DONE: begin
                n_out_valid = 1'b1;
                n_out_value = '0;
                n_out_inf   = 1'b0;
                n_out_bound = w_bound;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.entry_value  = r_out_value;
    assign o_out.entry_is_inf = r_out_inf;
    assign o_out.bound        = r_out_bound;

endmodule

// ===== rtl/core/crm_mem.sv =====
module crm_mem #(
    parameter int ADDR_W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_W-1:0]    i_waddr,
    input  crm_pkg::t_entry      i_wdata,
    input  logic [ADDR_W-1:0]    i_raddr,
    output crm_pkg::t_entry      o_rdata
);
    import crm_pkg::*;

    localparam int DEPTH = 1 << ADDR_W;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/crm_alu.sv =====
module crm_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  crm_pkg::t_alu_ctl             i_ctl,
    input  logic [crm_pkg::START_W-1:0]   i_start_cost,
    input  crm_pkg::t_entry               i_rdata,
    output logic                          o_found,
    output logic [crm_pkg::COST_W-1:0]    o_diff,
    output logic [crm_pkg::BOUND_W-1:0]   o_bound
);
    import crm_pkg::*;

    logic [COST_W-1:0]  r_min;
    logic               r_found;
    logic [BOUND_W-1:0] r_bound;
    logic [BOUND_W:0]   w_sum;
    logic               w_take;

    // running line minimum over finite entries
    assign w_take = i_ctl.scan_en && !i_rdata.inf && (!r_found || i_rdata.val < r_min);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear_line) begin
            r_found <= 1'b0;
        end else if (w_take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && !i_ctl.clear_line) begin
            r_min <= i_rdata.val;
        end
    end

    // saturating bound accumulator
    assign w_sum = {1'b0, r_bound} + (BOUND_W+1)'(r_min);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_bound) begin
            r_bound <= BOUND_W'(i_start_cost);
        end else if (i_ctl.acc_en && r_found) begin
            r_bound <= w_sum[BOUND_W] ? {BOUND_W{1'b1}} : w_sum[BOUND_W-1:0];
        end
    end

    assign o_found = r_found;
    assign o_diff  = i_rdata.val - r_min;
    assign o_bound = r_bound;

endmodule

// ===== rtl/core/crm_checker.sv =====
module crm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic [crm_pkg::CMD_W-1:0]     i_in_command,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [crm_pkg::COST_W-1:0]    i_out_entry_value,
    input logic                          i_out_entry_is_inf,
    input logic [crm_pkg::BOUND_W-1:0]   i_out_bound
);
    import crm_pkg::*;

    // a pending result word is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped before it was taken");

    // no command accepted while a result word is stuck
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready |-> (!i_out_valid || i_out_ready))
        else $error("input taken while output slot is full");

    // a read occupies the block for its memory latency
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_command == CMD_READ) |=> !i_in_ready)
        else $error("ready during read latency");

    // a nonzero bound only comes with a clear entry field
    a_bound_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_bound != '0) |->
            (i_out_entry_value == '0) && !i_out_entry_is_inf)
        else $error("bound word carries entry data");

endmodule

bind cost_matrix_row_column_reduction_top crm_checker u_crm_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in.valid),
    .i_in_ready         (i_in.ready),
    .i_in_command       (i_in.command),
    .i_out_valid        (o_out.valid),
    .i_out_ready        (o_out.ready),
    .i_out_entry_value  (o_out.entry_value),
    .i_out_entry_is_inf (o_out.entry_is_inf),
    .i_out_bound        (o_out.bound)
);
